// ===== rtl/core/rita_pkg.sv =====
// Package for the radix integer-to-ASCII converter: sizes, character codes,
// radix limits and the digit/radix helper functions. No dependencies.
package rita_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int DIGIT_SLOTS = 32;

  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int IDX_W     = $clog2(DIGIT_SLOTS);
  localparam int CNT_W     = $clog2(DIGIT_SLOTS + 1);
  localparam int BIT_CNT_W = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0]   RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0]   RADIX_MAX   = RADIX_W'(36);
  localparam logic [RADIX_W-1:0]   RADIX_RESET = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]    ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]    ASCII_A     = CHAR_W'(65);
  localparam logic [RADIX_W-1:0]   DEC_DIGITS  = RADIX_W'(10);
  localparam logic [BIT_CNT_W-1:0] BIT_LAST    = BIT_CNT_W'(VALUE_BITS - 1);
  localparam logic [CNT_W-1:0]     CNT_FULL    = CNT_W'(DIGIT_SLOTS);

  // Saturate a written base into the supported range.
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) res = RADIX_MIN;
    if (r > RADIX_MAX) res = RADIX_MAX;
    return res;
  endfunction

  // 0-9 -> '0'-'9', 10-35 -> 'A'-'Z'
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_DIGITS) c = ASCII_ZERO + CHAR_W'(d);
    else                c = ASCII_A + CHAR_W'(d - DEC_DIGITS);
    return c;
  endfunction

endpackage

// ===== rtl/core/radix_integer_to_ascii_top.sv =====
// Integer-to-string converter, radix 2..36, bit-serial restoring divider; uses rita_pkg.
// An accepted value is registered into the divider, which shifts through all VALUE_BITS (31)
// dividend bits per digit; each character is then a digit buffer read, then an output transfer.
// The output transfer waits while out_stall is high. One value at a time: the input stalls
// until the last character transfers. Synchronous active-low reset: idle, radix 10.
module radix_integer_to_ascii_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [rita_pkg::RADIX_W-1:0]        cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rita_pkg::VALUE_BITS-1:0]     in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rita_pkg::CHAR_W-1:0]         out_digit_char,
  output logic                                out_last_digit
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_READ, ST_SEND} state_t;

  state_t                             state_r;
  logic [rita_pkg::RADIX_W-1:0]       radix_r;
  logic [rita_pkg::VALUE_BITS-1:0]    quo_r;
  logic [rita_pkg::RADIX_W-1:0]       rem_r;
  logic [rita_pkg::BIT_CNT_W-1:0]     bit_cnt_r;
  logic [rita_pkg::CNT_W-1:0]         count_r;
  logic [rita_pkg::IDX_W-1:0]         ptr_r;
  logic [rita_pkg::RADIX_W-1:0]       rd_digit_r;

  logic [rita_pkg::RADIX_W-1:0]       digit_mem [rita_pkg::DIGIT_SLOTS];

  logic [rita_pkg::RADIX_W:0]         rem_sh;
  logic                               rem_ge;
  logic [rita_pkg::RADIX_W:0]         rem_diff;
  logic [rita_pkg::RADIX_W-1:0]       rem_nxt;
  logic [rita_pkg::VALUE_BITS-1:0]    quo_nxt;
  logic [rita_pkg::CNT_W-1:0]         count_nxt;
  logic                               div_last;
  logic                               conv_done;
  logic                               in_xfer;
  logic                               out_xfer;

  // One restoring step: shift in the next dividend bit, subtract the base if it fits.
  always_comb begin
    rem_sh    = {rem_r, quo_r[rita_pkg::VALUE_BITS-1]};
    rem_ge    = (rem_sh >= {1'b0, radix_r});
    rem_diff  = rem_sh - {1'b0, radix_r};
    rem_nxt   = rem_ge ? rem_diff[rita_pkg::RADIX_W-1:0] : rem_sh[rita_pkg::RADIX_W-1:0];
    quo_nxt   = {quo_r[rita_pkg::VALUE_BITS-2:0], rem_ge};
    count_nxt = count_r + 1'b1;
    div_last  = (state_r == ST_DIV) && (bit_cnt_r == rita_pkg::BIT_LAST);
    conv_done = (quo_nxt == '0) || (count_nxt == rita_pkg::CNT_FULL);
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_SEND);
  assign out_digit_char = rita_pkg::digit_to_ascii(rd_digit_r);
  assign out_last_digit = (ptr_r == '0);
  assign in_xfer        = in_valid && !in_stall;
  assign out_xfer       = out_valid && !out_stall;

  // Digit buffer, least significant digit at slot 0
  always_ff @(posedge clk) begin
    if (div_last) begin
      digit_mem[count_r[rita_pkg::IDX_W-1:0]] <= rem_nxt;
    end
    if (state_r == ST_READ) begin
      rd_digit_r <= digit_mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      radix_r   <= rita_pkg::RADIX_RESET;
      bit_cnt_r <= '0;
      count_r   <= '0;
      ptr_r     <= '0;
      quo_r     <= '0;
      rem_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        radix_r <= rita_pkg::clamp_radix(cfg_wr_data);
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            quo_r     <= in_value;
            rem_r     <= '0;
            bit_cnt_r <= '0;
            count_r   <= '0;
            state_r   <= ST_DIV;
          end
        end
        ST_DIV: begin
          quo_r <= quo_nxt;
          if (div_last) begin
            count_r   <= count_nxt;
            rem_r     <= '0;
            bit_cnt_r <= '0;
            if (conv_done) begin
              ptr_r   <= count_r[rita_pkg::IDX_W-1:0];
              state_r <= ST_READ;
            end
          end else begin
            rem_r     <= rem_nxt;
            bit_cnt_r <= bit_cnt_r + 1'b1;
          end
        end
        ST_READ: begin
          state_r <= ST_SEND;
        end
        ST_SEND: begin
          if (out_xfer) begin
            if (ptr_r == '0) begin
              state_r <= ST_IDLE;
            end else begin
              ptr_r   <= ptr_r - 1'b1;
              state_r <= ST_READ;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Partial remainder stays below the base while the base is not rewritten mid-division
  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < radix_r))
    else $error("partial remainder not below radix");

  // Digit slot being filled is inside the buffer
  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (count_r < rita_pkg::CNT_FULL))
    else $error("digit count overran buffer");

  // Accepted value starts a division
  a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_DIV) && (count_r == '0) && (bit_cnt_r == '0))
    else $error("accepted value did not start division");

  // Last character ends the conversion
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_digit) |=> (state_r == ST_IDLE))
    else $error("no return to idle after last character");

  // Non-last character leads to the next buffer read
  a_next_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && !out_last_digit) |=> (state_r == ST_READ) && (ptr_r == $past(ptr_r) - 1'b1))
    else $error("character sequence skipped");

endmodule
